FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the scheduler design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rrct_pkg.sv
// ----------------------------------------------------------------------------
// rrct_pkg
// Types and constants shared by the round-robin completion time block.
// ----------------------------------------------------------------------------
package rrct_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int BURST_W = 16;
  localparam int TIME_W  = 22;
  localparam int SUM_W   = 27;
  localparam int PIDX_W  = 6;
  localparam int ALU_W   = 27;
  localparam int TQ_W    = 16;

  localparam logic [TQ_W-1:0] TQ_RESET = TQ_W'(4);
  localparam logic            CFG_IDX_TQ = 1'b0;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_LOAD,  // taking bursts
    ST_RD,    // read remaining of current process
    ST_CMP,   // remaining minus quantum
    ST_ADV,   // advance clock, write back
    ST_ORD,   // read burst and finish for a record
    ST_WT,    // waiting = completion - burst
    ST_SW,    // accumulate waiting
    ST_ST,    // accumulate turnaround, load record
    ST_OUT    // record presented
  } state_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] waiting_time;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic              last_record;
  } out_rec_t;

endpackage

FILE: design/rrct_alu.sv
// ----------------------------------------------------------------------------
// rrct_alu
// Shared add/subtract unit; top bit is carry out or borrow.
// ----------------------------------------------------------------------------
module rrct_alu (
  input  rrct_pkg::alu_req_t       req,
  output logic [rrct_pkg::ALU_W:0] res
);
  import rrct_pkg::*;

  always_comb begin
    unique case (req.op)
      ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      default: res = '0;
    endcase
  end

endmodule

FILE: design/rrct_ctrl.sv
// ----------------------------------------------------------------------------
// rrct_ctrl
// Sequencer, process stores and record register for the scheduler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrct_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rrct_pkg::BURST_W-1:0]   in_burst,
  input  logic                           in_last,
  input  logic [rrct_pkg::TQ_W-1:0]      quantum,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rrct_pkg::out_rec_t             out_rec,
  output rrct_pkg::alu_req_t             alu_req,
  input  logic [rrct_pkg::ALU_W:0]       alu_res
);
  import rrct_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   active;
  logic [IDX_W-1:0]   idx;
  logic [TIME_W-1:0]  t;
  logic [BURST_W-1:0] diff;
  logic               gt;
  logic [TIME_W-1:0]  ct;
  logic [TIME_W-1:0]  wt;
  logic [SUM_W-1:0]   sum_w;
  logic [SUM_W-1:0]   sum_t;

  logic [BURST_W-1:0] burst_mem [MAX_PROCS];
  logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
  logic [TIME_W-1:0]  fin_mem   [MAX_PROCS];
  logic [BURST_W-1:0] burst_q;
  logic [BURST_W-1:0] rem_q;
  logic [TIME_W-1:0]  fin_q;

  logic               in_fire;
  logic               store_ok;
  logic               burst_nz;
  logic [CNT_W-1:0]   load_active;
  logic               idx_last;
  logic [IDX_W-1:0]   idx_wrap;
  logic [BURST_W-1:0] step;
  logic [TIME_W-1:0]  ct_c;
  logic               done_now;

  assign in_fire     = in_valid && in_ready;
  assign store_ok    = count < CNT_W'(MAX_PROCS);
  assign burst_nz    = in_burst != '0;
  assign load_active = active + CNT_W'(store_ok && burst_nz);
  assign idx_last    = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign idx_wrap    = idx_last ? '0 : idx + IDX_W'(1);
  assign step        = gt ? quantum : rem_q;
  assign ct_c        = (burst_q == '0) ? '0 : fin_q;
  assign done_now    = !gt && (active == CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_fire && in_last) begin
        state_next = (load_active == '0) ? ST_ORD : ST_RD;
      end
      ST_RD:   state_next = ST_CMP;
      ST_CMP:  state_next = (rem_q == '0) ? ST_RD : ST_ADV;
      ST_ADV:  state_next = done_now ? ST_ORD : ST_RD;
      ST_ORD:  state_next = ST_WT;
      ST_WT:   state_next = ST_SW;
      ST_SW:   state_next = ST_ST;
      ST_ST:   state_next = ST_OUT;
      ST_OUT: if (out_ready) begin
        state_next = idx_last ? ST_LOAD : ST_ORD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs and shared unit operands
  always_comb begin
    in_ready  = state == ST_LOAD;
    out_valid = state == ST_OUT;
    alu_req   = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state)
      ST_CMP: alu_req = '{op: ALU_SUB, a: ALU_W'(rem_q), b: ALU_W'(quantum)};
      ST_ADV: alu_req = '{op: ALU_ADD, a: ALU_W'(t), b: ALU_W'(step)};
      ST_WT:  alu_req = '{op: ALU_SUB, a: ALU_W'(ct_c), b: ALU_W'(burst_q)};
      ST_SW:  alu_req = '{op: ALU_ADD, a: sum_w, b: ALU_W'(wt)};
      ST_ST:  alu_req = '{op: ALU_ADD, a: sum_t, b: ALU_W'(ct)};
      default: alu_req = '{op: ALU_ADD, a: '0, b: '0};
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      count  <= '0;
      active <= '0;
      idx    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: if (in_fire) begin
          if (store_ok) count <= count + CNT_W'(1);
          active <= load_active;
          if (in_last) idx <= '0;
        end
        ST_CMP: if (rem_q == '0) idx <= idx_wrap;
        ST_ADV: begin
          if (!gt) active <= active - CNT_W'(1);
          idx <= done_now ? '0 : idx_wrap;
        end
        ST_OUT: if (out_ready) begin
          if (idx_last) begin
            count  <= '0;
            active <= '0;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: if (in_fire && in_last) begin
        t     <= '0;
        sum_w <= '0;
        sum_t <= '0;
      end
      ST_CMP: begin
        diff <= alu_res[BURST_W-1:0];
        gt   <= !alu_res[ALU_W] && (alu_res[BURST_W-1:0] != '0);
      end
      ST_ADV: t <= alu_res[TIME_W-1:0];
      ST_WT: begin
        ct <= ct_c;
        wt <= alu_res[TIME_W-1:0];
      end
      ST_SW: sum_w <= alu_res[SUM_W-1:0];
      ST_ST: begin
        out_rec.process_index    <= PIDX_W'(idx);
        out_rec.completion_time  <= ct;
        out_rec.waiting_time     <= wt;
        out_rec.total_waiting    <= sum_w;
        out_rec.total_turnaround <= alu_res[SUM_W-1:0];
        out_rec.last_record      <= idx_last;
        sum_t                    <= alu_res[SUM_W-1:0];
      end
      default: ;
    endcase
  end

  // process stores, registered reads
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && in_fire && store_ok) begin
      burst_mem[count[IDX_W-1:0]] <= in_burst;
    end
    if (state == ST_ORD) begin
      burst_q <= burst_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && in_fire && store_ok) begin
      rem_mem[count[IDX_W-1:0]] <= in_burst;
    end else if (state == ST_ADV) begin
      rem_mem[idx] <= gt ? diff : '0;
    end
    if (state == ST_RD) begin
      rem_q <= rem_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADV && !gt) begin
      fin_mem[idx] <= alu_res[TIME_W-1:0];
    end
    if (state == ST_ORD) begin
      fin_q <= fin_mem[idx];
    end
  end

  `AST_HOLDS(a_active_le_count, clk, rst, active <= count, "more active processes than stored")
  `AST_NEXT(a_finish_dec, clk, rst, state == ST_ADV && !gt, active == $past(active) - CNT_W'(1), "active count not decremented on finish")
  `AST_NEXT(a_last_rec_clears, clk, rst, out_valid && out_ready && out_rec.last_record, state == ST_LOAD && count == '0, "set not cleared after last record")

endmodule

FILE: design/round_robin_completion_times.sv
// Bursts are taken while loading. After the last burst, each scheduling turn
// steps through read, compare and advance, and each pass over a finished
// process through read and compare, both sharing the single adder.
// Each record then steps through read, waiting, both sums, output and any stall.
// Reset (rst, synchronous, active high) empties the set; time_quantum returns to 4.
// ----------------------------------------------------------------------------
// round_robin_completion_times
// Round-robin scheduling of up to MAX_PROCS bursts; one record per process.
// ----------------------------------------------------------------------------
module round_robin_completion_times (
  input  logic         clk,
  input  logic         rst,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [15:0] burst_time
  input  logic         s_tlast,   // last_process
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [5:0] process_index, [27:6] completion_time,
                                  // [49:28] waiting_time, [76:50] total_waiting,
                                  // [103:77] total_turnaround
  output logic         m_tlast    // last_record
);
  import rrct_pkg::*;

  logic [TQ_W-1:0] time_quantum;
  logic [TQ_W-1:0] quantum;
  logic            cfg_wr;
  alu_req_t        alu_req;
  logic [ALU_W:0]  alu_res;
  out_rec_t        out_rec;

  // Config write completes in the access phase; register 0 at byte 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_quantum <= TQ_RESET;
    end else if (cfg_wr && paddr[2] == CFG_IDX_TQ) begin
      time_quantum <= pwdata[TQ_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_TQ) ? {(32 - TQ_W)'(0), time_quantum} : '0;

  // A zero quantum behaves as one tick.
  assign quantum = (time_quantum == '0) ? TQ_W'(1) : time_quantum;

  rrct_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  rrct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_burst  (s_tdata[BURST_W-1:0]),
    .in_last   (s_tlast),
    .quantum   (quantum),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .alu_req   (alu_req),
    .alu_res   (alu_res)
  );

  // Record fields packed from the low bit up; 104 bits is already whole bytes.
  assign m_tdata = {out_rec.total_turnaround, out_rec.total_waiting,
                    out_rec.waiting_time, out_rec.completion_time,
                    out_rec.process_index};
  assign m_tlast = out_rec.last_record;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives burst sets into the round-robin completion time block across several
// time quanta. A scoreboard replays each set's schedule and checks every
// record field by field.
// ----------------------------------------------------------------------------
import rrct_pkg::*;

// Replays the round-robin schedule of each burst set and holds the records
// the block has still to return.
class rr_schedule_board;
  logic [TQ_W-1:0]    quantum;
  logic [BURST_W-1:0] bursts[$];
  out_rec_t           expected_records[$];
  int                 errors;

  function new();
    quantum = TQ_RESET;
    errors  = 0;
  endfunction

  function void set_quantum(logic [TQ_W-1:0] q);
    quantum = q;
  endfunction

  function int pending();
    return expected_records.size();
  endfunction

  // Accepted burst transaction; bursts past MAX_PROCS are dropped, but a
  // dropped last still starts the run.
  function void take_burst(logic [BURST_W-1:0] burst, logic last);
    if (bursts.size() < MAX_PROCS) bursts = {bursts, burst};
    if (last) begin
      schedule_set();
      bursts.delete();
    end
  endfunction

  function void schedule_set();
    logic [BURST_W-1:0] left[MAX_PROCS];
    logic [TIME_W-1:0]  done_at[MAX_PROCS];
    logic [TIME_W-1:0]  now;
    logic [TQ_W-1:0]    q;
    logic [SUM_W-1:0]   sum_wait;
    logic [SUM_W-1:0]   sum_tat;
    out_rec_t           rec;
    int                 n;
    int                 active;
    n        = bursts.size();
    now      = '0;
    active   = 0;
    sum_wait = '0;
    sum_tat  = '0;
    q        = (quantum == '0) ? TQ_W'(1) : quantum;  // zero quantum runs as one
    for (int i = 0; i < n; i++) begin
      left[i]    = bursts[i];
      done_at[i] = '0;  // zero bursts finish at tick 0
      if (left[i] != '0) active++;
    end
    while (active != 0) begin
      for (int i = 0; i < n; i++) begin
        if (left[i] == '0) continue;
        if (left[i] > q) begin
          now     = now + TIME_W'(q);
          left[i] = left[i] - q;
        end else begin
          now        = now + TIME_W'(left[i]);
          left[i]    = '0;
          done_at[i] = now;
          active--;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      rec.process_index    = PIDX_W'(i);
      rec.completion_time  = done_at[i];
      rec.waiting_time     = done_at[i] - TIME_W'(bursts[i]);
      sum_wait             = sum_wait + SUM_W'(rec.waiting_time);
      sum_tat              = sum_tat + SUM_W'(done_at[i]);
      rec.total_waiting    = sum_wait;
      rec.total_turnaround = sum_tat;
      rec.last_record      = (i == n - 1);
      expected_records     = {expected_records, rec};
    end
  endfunction

  function void compare_field(string name, logic [PIDX_W-1:0] proc,
                              longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: process %0d %s expected %0d actual %0d",
               $time, proc, name, want, got);
      errors++;
    end
  endfunction

  // Accepted record transaction from the output stream.
  function void check_record(logic [103:0] data, logic last);
    out_rec_t want;
    out_rec_t got;
    got.process_index    = data[5:0];
    got.completion_time  = data[27:6];
    got.waiting_time     = data[49:28];
    got.total_waiting    = data[76:50];
    got.total_turnaround = data[103:77];
    got.last_record      = last;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected record, process %0d expected none actual %h",
               $time, got.process_index, data);
      errors++;
      return;
    end
    want = expected_records.pop_front();
    compare_field("process_index", want.process_index, want.process_index,
                  got.process_index);
    compare_field("completion_time", want.process_index, want.completion_time,
                  got.completion_time);
    compare_field("waiting_time", want.process_index, want.waiting_time,
                  got.waiting_time);
    compare_field("total_waiting", want.process_index, want.total_waiting,
                  got.total_waiting);
    compare_field("total_turnaround", want.process_index, want.total_turnaround,
                  got.total_turnaround);
    compare_field("last_record", want.process_index, want.last_record,
                  got.last_record);
  endfunction
endclass

module tb;

  localparam int          RANDOM_ITEMS   = 200;
  localparam int          DRAIN_CYCLES   = 12;     // block settles back to loading
  localparam int          WATCHDOG_LIMIT = 20000;  // above the slowest set walk
  localparam int          ROUND_BUDGET   = 400;    // rounds x processes per random set
  localparam logic [2:0]  TQ_ADDR        = 3'(4 * CFG_IDX_TQ);

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata  = '0;  // [15:0] burst_time
  logic         s_tlast  = 1'b0;  // last_process
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;  // [5:0] process_index, [27:6] completion_time,
                          // [49:28] waiting_time, [76:50] total_waiting,
                          // [103:77] total_turnaround
  logic         m_tlast;  // last_record

  // calm: no idling on either side while set
  logic         calm     = 1'b0;
  int           idle_cycles = 0;

  rr_schedule_board sb;

  round_robin_completion_times uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Output side: check each accepted record, then pick next cycle's ready.
  // Values read here are the ones sampled by the edge itself.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_record(m_tdata, m_tlast);
    if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 8);
    end
  end

  // Watchdog: any transaction on any port counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d records outstanding",
               $time, idle_cycles, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Setup cycle then access cycle; the register takes the value at the
  // edge where the access phase sees pready.
  task automatic write_quantum(input logic [TQ_W-1:0] q);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TQ_ADDR;
    pwdata  <= 32'(q);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_quantum(q);
  endtask

  // One burst transaction, with an occasional gap in front of it.
  task automatic send_burst(input logic [BURST_W-1:0] burst, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= burst;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.take_burst(burst, last);
  endtask

  // Hold the sender until every record is back and the walk has settled.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TQ_W-1:0] pick_quantum();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return TQ_W'(1);
    if (r < 25) return '1;
    if (r < 30) return '0;
    if (r < 60) return TQ_W'($urandom_range(2, 16));
    return TQ_W'($urandom_range(1, 65535));
  endfunction

  // Bursts are capped so the number of rounds stays small for the set size;
  // zero bursts and bursts right at the quantum edge show up often.
  function automatic logic [BURST_W-1:0] pick_burst(int q_eff, int rounds_cap);
    int r;
    int cap;
    cap = q_eff * rounds_cap;
    if (cap > 65535) cap = 65535;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return BURST_W'(q_eff);
    if (r < 24) return (q_eff < 65535) ? BURST_W'(q_eff + 1) : BURST_W'(q_eff);
    return BURST_W'($urandom_range(1, cap));
  endfunction

  initial begin
    int               sent;
    int               set_no;
    int               n;
    int               q_eff;
    int               rounds_cap;
    int               r;
    logic [TQ_W-1:0]  q;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset quantum of 4, zero bursts, bursts at and around the
    // quantum, a lone zero burst, full bursts, quantum extremes and zero.
    send_burst(16'd0, 1'b1);
    send_burst(16'd5, 1'b0);
    send_burst(16'd0, 1'b0);
    send_burst(16'd4, 1'b0);
    send_burst(16'd9, 1'b0);
    send_burst(16'd3, 1'b1);
    wait_drain();
    write_quantum(16'hFFFF);
    send_burst(16'hFFFF, 1'b0);
    send_burst(16'd0, 1'b0);
    send_burst(16'hFFFF, 1'b1);
    wait_drain();
    write_quantum(16'd1);
    send_burst(16'd1, 1'b0);
    send_burst(16'd2, 1'b0);
    send_burst(16'd7, 1'b0);
    send_burst(16'd3, 1'b0);
    send_burst(16'd0, 1'b1);  // zero burst closing the set
    wait_drain();
    write_quantum(16'd0);
    send_burst(16'd2, 1'b0);
    send_burst(16'd1, 1'b1);
    wait_drain();

    // Random sets; some fill the store exactly, some overflow it.
    sent   = 0;
    set_no = 0;
    q      = sb.quantum;
    while (sent < RANDOM_ITEMS) begin
      calm <= (sent >= 80 && sent < 130);
      if (set_no == 0 || $urandom_range(0, 99) < 40) begin
        wait_drain();
        q = pick_quantum();
        write_quantum(q);
      end else if (set_no == 6) begin
        wait_drain();  // sender holds until every record is home
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
      end else if (r < 12) begin
        n = MAX_PROCS;
      end else begin
        n = $urandom_range(1, 8);
      end
      q_eff      = (q == '0) ? 1 : int'(q);
      rounds_cap = ROUND_BUDGET / ((n > MAX_PROCS) ? MAX_PROCS : n);
      for (int k = 0; k < n; k++) begin
        send_burst(pick_burst(q_eff, rounds_cap), k == n - 1);
      end
      sent   += n;
      set_no++;
    end
    calm <= 1'b0;
    wait_drain();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/rrct_pkg.sv
design/rrct_alu.sv
design/rrct_ctrl.sv
design/round_robin_completion_times.sv
tb/tb.sv
